/* rtl/core/rc5_pkg.sv */
// Shared types and constants for the RC5-32 block cipher core.
// No dependencies; imported by the core and its port checker.
package rc5_pkg;

    localparam int RC5_ROUNDS = 12;
    localparam int KEY_WORDS  = 4;

    localparam logic [31:0] SEED_P = 32'hB7E15163;
    localparam logic [31:0] STEP_Q = 32'h9E3779B9;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    localparam logic [1:0] OP_ENCRYPT = 2'd0;
    localparam logic [1:0] OP_DECRYPT = 2'd1;
    localparam logic [1:0] OP_EXPAND  = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MIX,
        ST_ENC,
        ST_DEC
    } state_t;

    // Operating modes of the shared half-round unit.
    typedef enum logic [2:0] {
        UM_ENC_INIT,
        UM_ENC_ROUND,
        UM_DEC_ROUND,
        UM_DEC_FINAL,
        UM_MIX_S,
        UM_MIX_L
    } unit_mode_t;

endpackage

/* rtl/core/rc5_block_cipher_core.sv */
// RC5-32 block cipher core: key registers, subkey memory, sequencer and one
// shared half-round unit (add/sub/xor, barrel rotate, add/xor). Uses rc5_pkg.
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------
//  request  | start, busy      | op, word_a, word_b
//  result   | done (strobe)    | out_a, out_b
//  config   | wr_en            | wr_index, wr_data
//
// An encrypt or decrypt item runs one half-round per cycle from acceptance to
// its done strobe, set by the single half-round unit and the one read port of
// the subkey memory. A key expansion makes a seeding pass of one entry a cycle,
// then runs each mixing iteration as a subkey half and then a key-word half.
// Op code 3 gives a zero result on the next cycle. The subkey memory reads as
// zero until the first expansion has seeded it. The receiver cannot stall;
// done lasts one cycle.
module rc5_block_cipher_core
    import rc5_pkg::*;
#(
    parameter int ROUNDS = RC5_ROUNDS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           op,
    input  logic [31:0]          word_a,
    input  logic [31:0]          word_b,
    output logic                 done,
    output logic [31:0]          out_a,
    output logic [31:0]          out_b,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [63:0]          wr_data
);

    localparam int TABLE_SIZE = 2 * (ROUNDS + 1);
    localparam int MIX_ITERS  = 3 * TABLE_SIZE;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(MIX_ITERS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0]  LAST_ITER = CNT_W'(MIX_ITERS - 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    iter_reg, iter_next;
    logic                half_reg, half_next;
    logic [1:0]          j_reg, j_next;
    logic [31:0]         a_reg, a_next;
    logic [31:0]         b_reg, b_next;
    logic [31:0]         seed_reg, seed_next;
    logic [31:0]         lw_reg [KEY_WORDS];
    logic [31:0]         lw_next [KEY_WORDS];
    logic                loaded_reg, loaded_next;
    logic                done_reg, done_next;
    logic [63:0]         key_low_reg, key_high_reg;

    logic [31:0]         mem [TABLE_SIZE];
    logic [31:0]         rdata_reg;
    logic [ADDR_W-1:0]   raddr;
    logic                mem_we;
    logic [31:0]         mem_wdata;

    // Shared unit
    unit_mode_t          unit_mode;
    logic [31:0]         unit_x, unit_y, unit_k;
    logic [31:0]         unit_sum, unit_pre, unit_rot, unit_res;
    logic [4:0]          unit_amt;

    logic                tgt_b;
    logic [31:0]         table_key;
    logic [ADDR_W-1:0]   addr_wrap;

    assign tgt_b     = addr_reg[0];
    assign table_key = loaded_reg ? rdata_reg : 32'd0;
    assign addr_wrap = (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;

    // Half-round unit: pre-operation, left rotation, post-operation.
    always_comb
    begin
        unit_sum = unit_x + unit_y;
        case (unit_mode)
            UM_ENC_INIT:  unit_pre = unit_x;
            UM_ENC_ROUND: unit_pre = unit_x ^ unit_y;
            UM_DEC_ROUND: unit_pre = unit_x - unit_k;
            UM_DEC_FINAL: unit_pre = unit_x - unit_k;
            UM_MIX_S:     unit_pre = unit_sum + unit_k;
            UM_MIX_L:     unit_pre = unit_sum + unit_k;
            default:      unit_pre = unit_x;
        endcase
        case (unit_mode)
            UM_ENC_ROUND: unit_amt = unit_y[4:0];
            UM_DEC_ROUND: unit_amt = 5'd0 - unit_y[4:0];
            UM_MIX_S:     unit_amt = 5'd3;
            UM_MIX_L:     unit_amt = unit_sum[4:0];
            default:      unit_amt = 5'd0;
        endcase
        unit_rot = (unit_pre << unit_amt) | (unit_pre >> (6'd32 - {1'b0, unit_amt}));
        case (unit_mode)
            UM_ENC_INIT:  unit_res = unit_rot + unit_k;
            UM_ENC_ROUND: unit_res = unit_rot + unit_k;
            UM_DEC_ROUND: unit_res = unit_rot ^ unit_y;
            default:      unit_res = unit_rot;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_ENCRYPT: state_next = ST_ENC;
                        OP_DECRYPT: state_next = ST_DEC;
                        OP_EXPAND:  state_next = ST_SEED;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEED:
            begin
                if (addr_reg == LAST_ADDR)
                    state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (half_reg && iter_reg == LAST_ITER)
                    state_next = ST_IDLE;
            end
            ST_ENC:
            begin
                if (addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_DEC:
            begin
                if (addr_reg == '0)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        addr_next   = addr_reg;
        iter_next   = iter_reg;
        half_next   = half_reg;
        j_next      = j_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        seed_next   = seed_reg;
        loaded_next = loaded_reg;
        done_next   = 1'b0;
        raddr       = '0;
        mem_we      = 1'b0;
        mem_wdata   = seed_reg;
        unit_mode   = UM_ENC_INIT;
        unit_x      = a_reg;
        unit_y      = b_reg;
        unit_k      = table_key;
        for (int n = 0; n < KEY_WORDS; n++)
            lw_next[n] = lw_reg[n];

        case (state_reg)
            ST_IDLE:
            begin
                raddr = (op == OP_DECRYPT) ? LAST_ADDR : '0;
                if (start)
                begin
                    case (op)
                        OP_ENCRYPT:
                        begin
                            a_next    = word_a;
                            b_next    = word_b;
                            addr_next = '0;
                        end
                        OP_DECRYPT:
                        begin
                            a_next    = word_a;
                            b_next    = word_b;
                            addr_next = LAST_ADDR;
                        end
                        OP_EXPAND:
                        begin
                            a_next    = 32'd0;
                            b_next    = 32'd0;
                            addr_next = '0;
                            iter_next = '0;
                            half_next = 1'b0;
                            j_next    = 2'd0;
                            seed_next = SEED_P;
                            lw_next[0] = key_low_reg[31:0];
                            lw_next[1] = key_low_reg[63:32];
                            lw_next[2] = key_high_reg[31:0];
                            lw_next[3] = key_high_reg[63:32];
                        end
                        default:
                        begin
                            a_next    = 32'd0;
                            b_next    = 32'd0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SEED:
            begin
                mem_we    = 1'b1;
                mem_wdata = seed_reg;
                seed_next = seed_reg + STEP_Q;
                addr_next = addr_wrap;
                raddr     = addr_wrap;
                if (addr_reg == LAST_ADDR)
                    loaded_next = 1'b1;
            end
            ST_MIX:
            begin
                unit_x = a_reg;
                unit_y = b_reg;
                if (!half_reg)
                begin
                    // Subkey half: rdata holds entry i, prefetch entry i+1.
                    unit_mode = UM_MIX_S;
                    unit_k    = rdata_reg;
                    a_next    = unit_res;
                    mem_we    = 1'b1;
                    mem_wdata = unit_res;
                    addr_next = addr_wrap;
                    raddr     = addr_wrap;
                    half_next = 1'b1;
                end
                else
                begin
                    unit_mode       = UM_MIX_L;
                    unit_k          = lw_reg[j_reg];
                    b_next          = unit_res;
                    lw_next[j_reg]  = unit_res;
                    j_next          = j_reg + 1'b1;
                    raddr           = addr_reg;
                    half_next       = 1'b0;
                    iter_next       = iter_reg + 1'b1;
                    if (iter_reg == LAST_ITER)
                    begin
                        a_next    = 32'd0;
                        b_next    = 32'd0;
                        done_next = 1'b1;
                    end
                end
            end
            ST_ENC:
            begin
                unit_mode = (addr_reg < ADDR_W'(2)) ? UM_ENC_INIT : UM_ENC_ROUND;
                unit_x    = tgt_b ? b_reg : a_reg;
                unit_y    = tgt_b ? a_reg : b_reg;
                unit_k    = table_key;
                if (tgt_b)
                    b_next = unit_res;
                else
                    a_next = unit_res;
                if (addr_reg == LAST_ADDR)
                    done_next = 1'b1;
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    raddr     = addr_reg + 1'b1;
                end
            end
            ST_DEC:
            begin
                unit_mode = (addr_reg < ADDR_W'(2)) ? UM_DEC_FINAL : UM_DEC_ROUND;
                unit_x    = tgt_b ? b_reg : a_reg;
                unit_y    = tgt_b ? a_reg : b_reg;
                unit_k    = table_key;
                if (tgt_b)
                    b_next = unit_res;
                else
                    a_next = unit_res;
                if (addr_reg == '0)
                    done_next = 1'b1;
                else
                begin
                    addr_next = addr_reg - 1'b1;
                    raddr     = addr_reg - 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            loaded_reg   <= 1'b0;
            done_reg     <= 1'b0;
            key_low_reg  <= 64'd0;
            key_high_reg <= 64'd0;
        end
        else
        begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            done_reg   <= done_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_KEY_LOW:  key_low_reg  <= wr_data;
                    REG_KEY_HIGH: key_high_reg <= wr_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        iter_reg <= iter_next;
        half_reg <= half_next;
        j_reg    <= j_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        seed_reg <= seed_next;
        for (int n = 0; n < KEY_WORDS; n++)
            lw_reg[n] <= lw_next[n];
    end

    // Subkey memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
        rdata_reg <= mem[raddr];
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign out_a = a_reg;
    assign out_b = b_reg;

endmodule

/* rtl/core/rc5_port_checker.sv */
// Port-level checks for the RC5-32 block cipher core, bound to its top level.
// Depends on rc5_pkg and rc5_block_cipher_core.
module rc5_port_checker
    import rc5_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  op,
    input logic        done,
    input logic [31:0] out_a,
    input logic [31:0] out_b
);

    // A result is only ever shown once the core has gone idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while core busy");

    // Every real operation keeps the core busy on the following cycle.
    a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op != OP_UNUSED) |=> busy)
        else $error("accepted item did not make core busy");

    // The unused code gives a zero result as soon as the request is registered.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_UNUSED) |=> (done && out_a == 32'd0 && out_b == 32'd0))
        else $error("unused op code did not give an immediate zero result");

    // Finishing work always comes with a result strobe.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("core went idle without a result");

endmodule

bind rc5_block_cipher_core rc5_port_checker u_port_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .op    (op),
    .done  (done),
    .out_a (out_a),
    .out_b (out_b)
);

/* sim/rc5_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard for the RC5-32 cipher core: it mirrors the key registers and
// the subkey table and predicts every result. Depends on rc5_pkg.
package rc5_tb_pkg;

    import rc5_pkg::*;

    localparam int TABLE_WORDS = 2 * (RC5_ROUNDS + 1);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } block_t;

    class rc5_cipher_scoreboard;

        logic [63:0] key_low_reg;
        logic [63:0] key_high_reg;
        logic [31:0] subkeys [TABLE_WORDS];
        block_t      pending_blocks [$];
        int          mismatches;
        int          results_checked;

        function new();
            key_low_reg     = '0;
            key_high_reg    = '0;
            foreach (subkeys[n])
                subkeys[n] = '0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void write_key(logic [CFG_IDX_W-1:0] index, logic [63:0] value);
            if (index == REG_KEY_LOW)
                key_low_reg = value;
            else if (index == REG_KEY_HIGH)
                key_high_reg = value;
        endfunction

        function int outstanding();
            return pending_blocks.size();
        endfunction

        static function logic [31:0] rotl(logic [31:0] x, logic [4:0] n);
            if (n == 5'd0)
                return x;
            return (x << n) | (x >> (6'd32 - n));
        endfunction

        static function logic [31:0] rotr(logic [31:0] x, logic [4:0] n);
            if (n == 5'd0)
                return x;
            return (x >> n) | (x << (6'd32 - n));
        endfunction

        function void expand_subkeys();
            logic [31:0] key_words [KEY_WORDS];
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] ab;
            int          i;
            int          j;
            key_words[0] = key_low_reg[31:0];
            key_words[1] = key_low_reg[63:32];
            key_words[2] = key_high_reg[31:0];
            key_words[3] = key_high_reg[63:32];
            subkeys[0] = SEED_P;
            for (int n = 1; n < TABLE_WORDS; n++)
                subkeys[n] = subkeys[n-1] + STEP_Q;
            a = '0;
            b = '0;
            i = 0;
            j = 0;
            // The table is longer than the key, so three passes over the table.
            for (int n = 0; n < 3 * TABLE_WORDS; n++)
            begin
                a = rotl(subkeys[i] + a + b, 5'd3);
                subkeys[i] = a;
                ab = a + b;
                b = rotl(key_words[j] + ab, ab[4:0]);
                key_words[j] = b;
                i = (i + 1) % TABLE_WORDS;
                j = (j + 1) % KEY_WORDS;
            end
        endfunction

        function block_t encipher(block_t blk);
            logic [31:0] a;
            logic [31:0] b;
            a = blk.a + subkeys[0];
            b = blk.b + subkeys[1];
            for (int r = 1; r <= RC5_ROUNDS; r++)
            begin
                a = rotl(a ^ b, b[4:0]) + subkeys[2*r];
                b = rotl(b ^ a, a[4:0]) + subkeys[2*r+1];
            end
            return '{a: a, b: b};
        endfunction

        function block_t decipher(block_t blk);
            logic [31:0] a;
            logic [31:0] b;
            a = blk.a;
            b = blk.b;
            for (int r = RC5_ROUNDS; r > 0; r--)
            begin
                b = rotr(b - subkeys[2*r+1], a[4:0]) ^ a;
                a = rotr(a - subkeys[2*r], b[4:0]) ^ b;
            end
            return '{a: a - subkeys[0], b: b - subkeys[1]};
        endfunction

        // Called for each accepted item; returns the block the core should give.
        function block_t note_request(logic [1:0] code, logic [31:0] word_a,
                                      logic [31:0] word_b);
            block_t blk;
            block_t res;
            blk = '{a: word_a, b: word_b};
            case (code)
                OP_ENCRYPT: res = encipher(blk);
                OP_DECRYPT: res = decipher(blk);
                OP_EXPAND:
                begin
                    expand_subkeys();
                    res = '0;
                end
                default:    res = '0;
            endcase
            pending_blocks.push_back(res);
            return res;
        endfunction

        function void check_result(logic [31:0] out_a, logic [31:0] out_b);
            block_t want;
            results_checked++;
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected result, out_a %h out_b %h", $time, out_a, out_b);
                mismatches++;
                return;
            end
            want = pending_blocks.pop_front();
            if (want.a !== out_a)
            begin
                $display("%0t: out_a mismatch, expected %h actual %h", $time, want.a, out_a);
                mismatches++;
            end
            if (want.b !== out_b)
            begin
                $display("%0t: out_b mismatch, expected %h actual %h", $time, want.b, out_b);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top-level testbench for rc5_block_cipher_core: directed and random items
// under changing keys, checked by the scoreboard in rc5_tb_pkg.
module tb_top;

    import rc5_pkg::*;
    import rc5_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int TARGET_ITEMS = 1550;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = 2'd3;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic [1:0]  op       = OP_ENCRYPT;
    logic [31:0] word_a   = '0;
    logic [31:0] word_b   = '0;
    logic        wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = REG_KEY_LOW;
    logic [63:0] wr_data  = '0;
    logic        busy;
    logic        done;
    logic [31:0] out_a;
    logic [31:0] out_b;

    rc5_cipher_scoreboard sb = new();

    block_t last_result;
    block_t last_cipher;
    logic   have_cipher = 1'b0;
    int     items_sent = 0;
    int     n_encrypt = 0;
    int     n_decrypt = 0;
    int     n_expand = 0;
    int     n_unused = 0;
    int     key_settings = 0;

    rc5_block_cipher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .word_a   (word_a),
        .word_b   (word_b),
        .done     (done),
        .out_a    (out_a),
        .out_b    (out_b),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(out_a, out_b);
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Holds the item until the core takes it, then idles for the gap that the caller asks for.
    task automatic issue_item(input logic [1:0] code, input logic [31:0] a,
                              input logic [31:0] b, input int gap);
        @(negedge clk);
        start  = 1'b1;
        op     = code;
        word_a = a;
        word_b = b;
        do
            @(posedge clk);
        while (busy);
        last_result = sb.note_request(code, a, b);
        case (code)
            OP_ENCRYPT:
            begin
                n_encrypt++;
                last_cipher = last_result;
                have_cipher = 1'b1;
            end
            OP_DECRYPT: n_decrypt++;
            OP_EXPAND:  n_expand++;
            default:    n_unused++;
        endcase
        if (code != OP_UNUSED)
            items_sent++;
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (sb.outstanding() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = index;
        wr_data  = value;
        sb.write_key(index, value);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        int k;
        k = $urandom_range(0, 31);
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << k;
            3:       return ~(32'h1 << k);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 64'h0;
            1:       return {64{1'b1}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        int          phase_len;
        int          gap;
        int          pick;
        logic        no_idle;
        logic [1:0]  code;
        logic [31:0] a;
        logic [31:0] b;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: the all-zero table before any expansion, extreme words,
        // the unused code, and expansions from extreme and random keys.
        issue_item(OP_ENCRYPT, 32'h0, 32'h0, 0);
        issue_item(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3);
        issue_item(OP_DECRYPT, 32'h0, 32'h0, 0);
        issue_item(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0, 0);
        issue_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue_item(OP_EXPAND, 32'h0, 32'h0, 0);
        issue_item(OP_ENCRYPT, 32'h0, 32'h0, 0);
        issue_item(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 0);
        settle();
        write_reg(REG_KEY_LOW, {64{1'b1}});
        write_reg(REG_KEY_HIGH, {64{1'b1}});
        issue_item(OP_EXPAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue_item(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue_item(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        settle();
        write_reg(REG_SPARE_0, {64{1'b1}});
        write_reg(REG_SPARE_1, {64{1'b1}});
        write_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_reg(REG_KEY_HIGH, {$urandom, $urandom});
        issue_item(OP_EXPAND, $urandom, $urandom, 0);
        issue_item(OP_ENCRYPT, $urandom, $urandom, 0);
        issue_item(OP_DECRYPT, last_cipher.a, last_cipher.b, 0);
        issue_item(OP_UNUSED, $urandom, $urandom, 0);
        issue_item(OP_EXPAND, $urandom, $urandom, 0);
        issue_item(OP_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 0);
        key_settings = 3;

        // Random phases: each starts idle with a new key setting, usually
        // followed by an expansion, then a run of mixed items.
        while (items_sent < TARGET_ITEMS)
        begin
            settle();
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 1))
            begin
                if (pick != 0)
                    write_reg(REG_KEY_LOW, pick_key());
                if (pick != 1)
                    write_reg(REG_KEY_HIGH, pick_key());
            end
            else
            begin
                if (pick != 1)
                    write_reg(REG_KEY_HIGH, pick_key());
                if (pick != 0)
                    write_reg(REG_KEY_LOW, pick_key());
            end
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_0 : REG_SPARE_1,
                          {$urandom, $urandom});
            key_settings++;
            if ($urandom_range(0, 9) != 0)
                issue_item(OP_EXPAND, $urandom, $urandom, $urandom_range(0, 15));

            phase_len = $urandom_range(20, 120);
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                a = pick_word();
                b = pick_word();
                if (pick < 42)
                    code = OP_ENCRYPT;
                else if (pick < 58 && have_cipher)
                begin
                    // Feed back the latest ciphertext to exercise the round trip.
                    code = OP_DECRYPT;
                    a = last_cipher.a;
                    b = last_cipher.b;
                end
                else if (pick < 90)
                    code = OP_DECRYPT;
                else if (pick < 95)
                    code = OP_EXPAND;
                else
                    code = OP_UNUSED;
                gap = no_idle ? 0 : $urandom_range(0, 15);
                issue_item(code, a, b, gap);
            end
        end

        settle();
        repeat (2 * RC5_ROUNDS + 8) @(negedge clk);

        $display("Ran %0d encrypt, %0d decrypt, %0d expansion and %0d unused-code items",
                 n_encrypt, n_decrypt, n_expand, n_unused);
        $display("over %0d key settings; %0d results compared, %0d mismatches.",
                 key_settings, sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/rc5_pkg.sv
rtl/core/rc5_block_cipher_core.sv
rtl/core/rc5_port_checker.sv
sim/rc5_tb_pkg.sv
sim/tb_top.sv
